FILE: src/nand_netlist_tick_engine_core_macros.svh
// Assertion helpers used by the RTL of the tick engine core.
`ifndef NAND_NETLIST_TICK_ENGINE_CORE_MACROS_SVH
`define NAND_NETLIST_TICK_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define NNTE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nnte assertion failed");

// Next-cycle implication.
`define NNTE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nnte assertion failed");

`endif

FILE: src/nnte_pkg.sv
package nnte_pkg;

  // Command codes carried by in_command.
  localparam logic [2:0] CMD_SET_SRC  = 3'd0;
  localparam logic [2:0] CMD_SET_CNT  = 3'd1;
  localparam logic [2:0] CMD_POKE     = 3'd2;
  localparam logic [2:0] CMD_BIND     = 3'd3;
  localparam logic [2:0] CMD_TICK     = 3'd4;
  localparam logic [2:0] CMD_RD_NODE  = 3'd5;
  localparam logic [2:0] CMD_RD_RAM   = 3'd6;

  // Hook kinds carried by in_hook_kind.
  localparam logic [2:0] HOOK_KEY     = 3'd0;
  localparam logic [2:0] HOOK_ADDR    = 3'd1;
  localparam logic [2:0] HOOK_DIN     = 3'd2;
  localparam logic [2:0] HOOK_DOUT    = 3'd3;
  localparam logic [2:0] HOOK_WE      = 3'd4;

  // Bus geometry of the RAM hooks.
  localparam int ADDR_BITS = 16;
  localparam int DATA_BITS = 8;
  // Address bits, then data-in bits, then write enable.
  localparam logic [4:0] BUS_LAST_ADDR = 5'd15;
  localparam logic [4:0] BUS_LAST_DIN  = 5'd23;
  localparam logic [4:0] BUS_LAST      = 5'd24;

  typedef logic [2:0] cmd_t;

endpackage

FILE: src/nnte_ram.sv
module nnte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/nand_netlist_tick_engine_core.sv
// Channel   Handshake                 Payload
// command   start / busy              in_command .. in_mem_address
// result    out_valid (strobe)        out_node_value, out_mem_byte, out_status
// config    cfg_valid / cfg_ready     cfg_nodes_in_use
//
// Set, poke, bind and unknown commands finish in S_EXEC; node and RAM reads add S_RDWT.
// A tick visits all NODE_COUNT nodes in turn, as the value memory has one read port:
// idle or fan-in-free nodes pass through S_NODE and S_NCAP, other nodes also walk
// their fan-ins in S_FAN. Hook, RAM and data-out work and address reduction follow.
// After reset a clearing pass over max(RAM_WORDS, NODE_COUNT) entries keeps busy high.
// Results are strobed for one cycle; the receiver cannot stall them.
`include "nand_netlist_tick_engine_core_macros.svh"

module nand_netlist_tick_engine_core
  import nnte_pkg::*;
#(
  parameter int NODE_COUNT = 4096,
  parameter int FANIN_MAX  = 16,
  parameter int KEY_SLOTS  = 32,
  parameter int RAM_WORDS  = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_command,
  input  logic [11:0] in_node,
  input  logic [4:0]  in_slot,
  input  logic [11:0] in_source_node,
  input  logic [4:0]  in_fanin_total,
  input  logic        in_poke_value,
  input  logic [2:0]  in_hook_kind,
  input  logic        in_hook_valid,
  input  logic [31:0] in_key_values,
  input  logic [15:0] in_mem_address,
  output logic        out_valid,
  output logic        out_node_value,
  output logic [7:0]  out_mem_byte,
  output logic        out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_nodes_in_use
);

  // Derived geometry.
  localparam int NW  = $clog2(NODE_COUNT);
  localparam int FW  = $clog2(FANIN_MAX + 1);
  localparam int TD  = NODE_COUNT * FANIN_MAX;
  localparam int TAW = $clog2(TD);
  localparam int KSW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int RAW = $clog2(RAM_WORDS);
  localparam int CLR_DEPTH = (RAM_WORDS > NODE_COUNT) ? RAM_WORDS : NODE_COUNT;
  localparam int CLW = $clog2(CLR_DEPTH);

  localparam logic [12:0] NODE_LIM  = 13'(NODE_COUNT);
  localparam logic [16:0] RAM_LIM   = 17'(RAM_WORDS);

  // Sequencer states.
  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_EXEC  = 5'd2;
  localparam logic [4:0] S_RDWT  = 5'd3;
  localparam logic [4:0] S_NODE  = 5'd4;
  localparam logic [4:0] S_NCAP  = 5'd5;
  localparam logic [4:0] S_FAN   = 5'd6;
  localparam logic [4:0] S_KEY   = 5'd7;
  localparam logic [4:0] S_BRD   = 5'd8;
  localparam logic [4:0] S_BCAP  = 5'd9;
  localparam logic [4:0] S_MOD   = 5'd10;
  localparam logic [4:0] S_RAMW  = 5'd11;
  localparam logic [4:0] S_RRD   = 5'd12;
  localparam logic [4:0] S_RCAP  = 5'd13;
  localparam logic [4:0] S_DOUT  = 5'd14;
  localparam logic [4:0] S_DONE  = 5'd15;

  logic [4:0]  state_r, state_nxt;
  logic [CLW-1:0] clr_r, clr_nxt;

  // Latched command beat.
  cmd_t        cmd_r;
  logic [11:0] node_r, src_r;
  logic [4:0]  slot_r, total_r;
  logic        pv_r, valid_r;
  logic [2:0]  kind_r;
  logic [KEY_SLOTS-1:0] keys_r;
  logic [15:0] maddr_r;

  logic [12:0] nodes_in_use_r;
  logic        sel_r, sel_nxt;

  // Tick walk state.
  logic [NW-1:0]  i_r, i_nxt;
  logic [TAW-1:0] base_r, base_nxt;
  logic [FW-1:0]  cnt_r, cnt_nxt, iss_r, iss_nxt, done_r, done_nxt;
  logic           acc_r, acc_nxt, p1_r, p1_nxt, p2_r, p2_nxt;
  logic [KSW-1:0] k_r, k_nxt;
  logic [4:0]     bi_r, bi_nxt;
  logic [15:0]    ad_r, ad_nxt;
  logic [7:0]     din_r, din_nxt, q_r, q_nxt;
  logic           we_r, we_nxt, any_r, any_nxt;
  logic [2:0]     d_r, d_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        out_nv_r, out_nv_nxt, out_st_r, out_st_nxt;
  logic [7:0]  out_mb_r, out_mb_nxt;

  // Hook bindings: bit NW is the bound flag.
  logic [NW:0] key_bind_r  [KEY_SLOTS];
  logic [NW:0] addr_bind_r [ADDR_BITS];
  logic [NW:0] din_bind_r  [DATA_BITS];
  logic [NW:0] dout_bind_r [DATA_BITS];
  logic [NW:0] we_bind_r;
  logic        bind_wr;
  logic [NW:0] bind_v;

  // Memory ports.
  logic          val_cur_we, val_nxt_we, val_clr_we, val_we0, val_we1;
  logic [NW-1:0] val_wa, val_ra;
  logic          val_wd, val_q0, val_q1, val_q;
  logic          cnt_we;
  logic [NW-1:0] cnt_wa, cnt_ra;
  logic [FW-1:0] cnt_wd, cnt_q;
  logic          fan_we;
  logic [TAW-1:0] fan_wa, fan_ra;
  logic [NW-1:0] fan_wd, fan_q;
  logic          mem_we;
  logic [RAW-1:0] mem_wa, mem_ra;
  logic [7:0]    mem_wd, mem_q;

  // Helpers.
  logic          node_bad, adv, last_node, in_use;
  logic [12:0]   use_lim;
  logic [FW-1:0] done_inc;
  logic [NW:0]   bus_b;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_node_value = out_nv_r;
  assign out_mem_byte   = out_mb_r;
  assign out_status     = out_st_r;

  assign val_q     = sel_r ? val_q1 : val_q0;
  assign node_bad  = ({1'b0, node_r} >= NODE_LIM);
  assign use_lim   = (nodes_in_use_r > NODE_LIM) ? NODE_LIM : nodes_in_use_r;
  assign in_use    = (13'(i_r) < use_lim);
  assign last_node = (i_r == NW'(NODE_COUNT - 1));
  assign done_inc  = done_r + FW'(1);

  // The current bank is sel_r; the tick writes the other one.
  assign val_we1 = (val_cur_we & sel_r) | (val_nxt_we & ~sel_r) | val_clr_we;
  assign val_we0 = (val_cur_we & ~sel_r) | (val_nxt_we & sel_r) | val_clr_we;

  // Hook read during the bus phase: address bits, then data-in bits, then
  // the write enable.
  always_comb begin
    if (bi_r <= BUS_LAST_ADDR) begin
      bus_b = addr_bind_r[bi_r[3:0]];
    end else if (bi_r <= BUS_LAST_DIN) begin
      bus_b = din_bind_r[3'(bi_r - 5'd16)];
    end else begin
      bus_b = we_bind_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    sel_nxt   = sel_r;
    i_nxt     = i_r;
    base_nxt  = base_r;
    cnt_nxt   = cnt_r;
    iss_nxt   = iss_r;
    done_nxt  = done_r;
    acc_nxt   = acc_r;
    p1_nxt    = 1'b0;
    p2_nxt    = 1'b0;
    k_nxt     = k_r;
    bi_nxt    = bi_r;
    ad_nxt    = ad_r;
    din_nxt   = din_r;
    we_nxt    = we_r;
    any_nxt   = any_r;
    q_nxt     = q_r;
    d_nxt     = d_r;
    out_valid_nxt = 1'b0;
    out_nv_nxt    = 1'b0;
    out_mb_nxt    = 8'd0;
    out_st_nxt    = 1'b0;
    bind_wr   = 1'b0;
    bind_v    = '0;
    adv       = 1'b0;
    val_cur_we = 1'b0;
    val_nxt_we = 1'b0;
    val_clr_we = 1'b0;
    val_wa    = i_r;
    val_wd    = 1'b0;
    val_ra    = i_r;
    cnt_we    = 1'b0;
    cnt_wa    = node_r[NW-1:0];
    cnt_wd    = FW'(total_r);
    cnt_ra    = i_r;
    fan_we    = 1'b0;
    fan_wa    = TAW'(node_r[NW-1:0]) * TAW'(FANIN_MAX) + TAW'(slot_r);
    fan_wd    = src_r[NW-1:0];
    fan_ra    = base_r + TAW'(iss_r);
    mem_we    = 1'b0;
    mem_wa    = ad_r[RAW-1:0];
    mem_wd    = din_r;
    mem_ra    = maddr_r[RAW-1:0];

    unique case (state_r)
      S_CLEAR: begin
        // Zero the value banks, the fan-in counts and the RAM, one entry a cycle.
        if ({1'b0, clr_r} < (CLW+1)'(NODE_COUNT)) begin
          val_clr_we = 1'b1;
          val_wa     = clr_r[NW-1:0];
          cnt_we     = 1'b1;
          cnt_wa     = clr_r[NW-1:0];
          cnt_wd     = '0;
        end
        if ({1'b0, clr_r} < (CLW+1)'(RAM_WORDS)) begin
          mem_we = 1'b1;
          mem_wa = clr_r[RAW-1:0];
          mem_wd = 8'd0;
        end
        clr_nxt = clr_r + CLW'(1);
        if (clr_r == CLW'(CLR_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        unique case (cmd_r)
          CMD_SET_SRC: begin
            if (node_bad || ({1'b0, slot_r} >= 6'(FANIN_MAX)) ||
                ({1'b0, src_r} >= NODE_LIM)) begin
              out_st_nxt = 1'b1;
            end else begin
              fan_we = 1'b1;
            end
          end
          CMD_SET_CNT: begin
            if (node_bad || ({1'b0, total_r} > 6'(FANIN_MAX))) begin
              out_st_nxt = 1'b1;
            end else begin
              cnt_we = 1'b1;
            end
          end
          CMD_POKE: begin
            if (node_bad) begin
              out_st_nxt = 1'b1;
            end else begin
              val_cur_we = 1'b1;
              val_wa     = node_r[NW-1:0];
              val_wd     = pv_r;
            end
          end
          CMD_BIND: begin
            bind_v = valid_r ? {1'b1, node_r[NW-1:0]} : '0;
            if (valid_r && node_bad) begin
              out_st_nxt = 1'b1;
            end else begin
              priority if (kind_r == HOOK_KEY) begin
                out_st_nxt = ({1'b0, slot_r} >= 6'(KEY_SLOTS));
              end else if (kind_r == HOOK_ADDR) begin
                out_st_nxt = ({1'b0, slot_r} >= 6'(ADDR_BITS));
              end else if (kind_r == HOOK_DIN || kind_r == HOOK_DOUT) begin
                out_st_nxt = ({1'b0, slot_r} >= 6'(DATA_BITS));
              end else if (kind_r == HOOK_WE) begin
                out_st_nxt = 1'b0;
              end else begin
                out_st_nxt = 1'b1;
              end
              bind_wr = ~out_st_nxt;
            end
          end
          CMD_TICK: begin
            out_valid_nxt = 1'b0;
            i_nxt     = '0;
            base_nxt  = '0;
            state_nxt = S_NODE;
          end
          CMD_RD_NODE: begin
            if (node_bad) begin
              out_st_nxt = 1'b1;
            end else begin
              out_valid_nxt = 1'b0;
              val_ra    = node_r[NW-1:0];
              state_nxt = S_RDWT;
            end
          end
          CMD_RD_RAM: begin
            if ({1'b0, maddr_r} >= RAM_LIM) begin
              out_st_nxt = 1'b1;
            end else begin
              out_valid_nxt = 1'b0;
              state_nxt = S_RDWT;
            end
          end
          default: begin
            out_st_nxt = 1'b1;
          end
        endcase
      end
      S_RDWT: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (cmd_r == CMD_RD_NODE) begin
          out_nv_nxt = val_q;
        end else begin
          out_mb_nxt = mem_q;
        end
      end
      S_NODE: begin
        state_nxt = S_NCAP;
      end
      S_NCAP: begin
        if (!in_use) begin
          val_nxt_we = 1'b1;
          val_wd     = val_q;
          adv        = 1'b1;
        end else if (cnt_q == '0) begin
          val_nxt_we = 1'b1;
          val_wd     = 1'b0;
          adv        = 1'b1;
        end else begin
          cnt_nxt   = cnt_q;
          iss_nxt   = '0;
          done_nxt  = '0;
          acc_nxt   = 1'b1;
          state_nxt = S_FAN;
        end
      end
      S_FAN: begin
        // Three-deep walk: fan-in entry read, source value read, AND.
        if (iss_r < cnt_r) begin
          iss_nxt = iss_r + FW'(1);
          p1_nxt  = 1'b1;
        end
        if (p1_r) begin
          val_ra = fan_q;
          p2_nxt = 1'b1;
        end
        if (p2_r) begin
          acc_nxt  = acc_r & val_q;
          done_nxt = done_inc;
          if (done_inc == cnt_r) begin
            val_nxt_we = 1'b1;
            val_wd     = ~(acc_r & val_q);
            adv        = 1'b1;
          end
        end
      end
      S_KEY: begin
        if (key_bind_r[k_r][NW]) begin
          val_nxt_we = 1'b1;
          val_wa     = key_bind_r[k_r][NW-1:0];
          val_wd     = keys_r[k_r];
        end
        k_nxt = k_r + KSW'(1);
        if (k_r == KSW'(KEY_SLOTS - 1)) begin
          bi_nxt    = '0;
          ad_nxt    = '0;
          din_nxt   = '0;
          we_nxt    = 1'b0;
          any_nxt   = 1'b0;
          state_nxt = S_BRD;
        end
      end
      S_BRD: begin
        val_ra    = bus_b[NW-1:0];
        state_nxt = S_BCAP;
      end
      S_BCAP: begin
        if (bi_r <= BUS_LAST_ADDR) begin
          ad_nxt[bi_r[3:0]] = bus_b[NW] & val_q;
          any_nxt = any_r | bus_b[NW];
        end else if (bi_r <= BUS_LAST_DIN) begin
          din_nxt[3'(bi_r - 5'd16)] = bus_b[NW] & val_q;
        end else begin
          we_nxt = bus_b[NW] & val_q;
        end
        bi_nxt    = bi_r + 5'd1;
        state_nxt = (bi_r == BUS_LAST) ? S_MOD : S_BRD;
      end
      S_MOD: begin
        // No address hook bound: skip the RAM. Else reduce the address by repeated subtraction of the RAM size.
        if (!any_r) begin
          state_nxt = S_DONE;
        end else if ({1'b0, ad_r} >= RAM_LIM) begin
          ad_nxt = ad_r - 16'(RAM_WORDS);
        end else begin
          state_nxt = S_RAMW;
        end
      end
      S_RAMW: begin
        mem_we    = we_r;
        state_nxt = S_RRD;
      end
      S_RRD: begin
        mem_ra    = ad_r[RAW-1:0];
        state_nxt = S_RCAP;
      end
      S_RCAP: begin
        q_nxt     = mem_q;
        d_nxt     = '0;
        state_nxt = S_DOUT;
      end
      S_DOUT: begin
        if (dout_bind_r[d_r][NW]) begin
          val_nxt_we = 1'b1;
          val_wa     = dout_bind_r[d_r][NW-1:0];
          val_wd     = q_r[d_r];
        end
        d_nxt = d_r + 3'd1;
        if (d_r == 3'(DATA_BITS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        sel_nxt       = ~sel_r;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (adv) begin
      i_nxt    = i_r + NW'(1);
      base_nxt = base_r + TAW'(FANIN_MAX);
      if (last_node) begin
        k_nxt     = '0;
        state_nxt = S_KEY;
      end else begin
        state_nxt = S_NODE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      clr_r          <= '0;
      sel_r          <= 1'b0;
      p1_r           <= 1'b0;
      p2_r           <= 1'b0;
      out_valid_r    <= 1'b0;
      nodes_in_use_r <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      sel_r       <= sel_nxt;
      p1_r        <= p1_nxt;
      p2_r        <= p2_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        nodes_in_use_r <= cfg_nodes_in_use;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      cmd_r   <= in_command;
      node_r  <= in_node;
      slot_r  <= in_slot;
      src_r   <= in_source_node;
      total_r <= in_fanin_total;
      pv_r    <= in_poke_value;
      kind_r  <= in_hook_kind;
      valid_r <= in_hook_valid;
      keys_r  <= in_key_values[KEY_SLOTS-1:0];
      maddr_r <= in_mem_address;
    end
    i_r      <= i_nxt;
    base_r   <= base_nxt;
    cnt_r    <= cnt_nxt;
    iss_r    <= iss_nxt;
    done_r   <= done_nxt;
    acc_r    <= acc_nxt;
    k_r      <= k_nxt;
    bi_r     <= bi_nxt;
    ad_r     <= ad_nxt;
    din_r    <= din_nxt;
    we_r     <= we_nxt;
    any_r    <= any_nxt;
    q_r      <= q_nxt;
    d_r      <= d_nxt;
    out_nv_r <= out_nv_nxt;
    out_mb_r <= out_mb_nxt;
    out_st_r <= out_st_nxt;
  end

  // Hook bindings start out unbound.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < KEY_SLOTS; s++) key_bind_r[s] <= '0;
      for (int s = 0; s < ADDR_BITS; s++) addr_bind_r[s] <= '0;
      for (int s = 0; s < DATA_BITS; s++) begin
        din_bind_r[s]  <= '0;
        dout_bind_r[s] <= '0;
      end
      we_bind_r <= '0;
    end else if (bind_wr) begin
      unique case (kind_r)
        HOOK_KEY:  key_bind_r[slot_r[KSW-1:0]] <= bind_v;
        HOOK_ADDR: addr_bind_r[slot_r[3:0]]    <= bind_v;
        HOOK_DIN:  din_bind_r[slot_r[2:0]]     <= bind_v;
        HOOK_DOUT: dout_bind_r[slot_r[2:0]]    <= bind_v;
        default:   we_bind_r                   <= bind_v;
      endcase
    end
  end

  // Two value banks swap roles at the end of every tick.
  nnte_ram #(.WIDTH(1), .DEPTH(NODE_COUNT)) u_val0 (
    .clk(clk), .we(val_we0), .waddr(val_wa), .wdata(val_wd),
    .raddr(val_ra), .rdata(val_q0)
  );

  nnte_ram #(.WIDTH(1), .DEPTH(NODE_COUNT)) u_val1 (
    .clk(clk), .we(val_we1), .waddr(val_wa), .wdata(val_wd),
    .raddr(val_ra), .rdata(val_q1)
  );

  nnte_ram #(.WIDTH(FW), .DEPTH(NODE_COUNT)) u_cnt (
    .clk(clk), .we(cnt_we), .waddr(cnt_wa), .wdata(cnt_wd),
    .raddr(cnt_ra), .rdata(cnt_q)
  );

  nnte_ram #(.WIDTH(NW), .DEPTH(TD)) u_fan (
    .clk(clk), .we(fan_we), .waddr(fan_wa), .wdata(fan_wd),
    .raddr(fan_ra), .rdata(fan_q)
  );

  nnte_ram #(.WIDTH(8), .DEPTH(RAM_WORDS)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_wa), .wdata(mem_wd),
    .raddr(mem_ra), .rdata(mem_q)
  );

  `NNTE_ASSERT_NOW(a_strobe_idle, out_valid, !busy)
  `NNTE_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `NNTE_ASSERT_NOW(a_fan_pipe, p2_r || p1_r, state_r == S_FAN)
  `NNTE_ASSERT_NEXT(a_bank_hold, state_r != S_DONE, $stable(sel_r))

endmodule

FILE: tb/sv/tb_nand_netlist_tick_engine_core.sv
`default_nettype none

// Fields of one command beat, as driven onto the in_ ports.
typedef struct {
  nnte_pkg::cmd_t command;
  logic [11:0]    node;
  logic [4:0]     slot;
  logic [11:0]    source_node;
  logic [4:0]     fanin_total;
  logic           poke_value;
  logic [2:0]     hook_kind;
  logic           hook_valid;
  logic [31:0]    key_values;
  logic [15:0]    mem_address;
} engine_cmd_t;

// Fields of one result beat.
typedef struct {
  logic       node_value;
  logic [7:0] mem_byte;
  logic       status;
} engine_result_t;

// Shadow copy of the netlist engine. Every accepted command is applied to the
// shadow state and queues the one result the engine must return for it.
class tick_engine_scoreboard;
  localparam int NODES = 4096;
  localparam int FANIN = 16;

  bit             node_val[NODES];
  bit [4:0]       fanin_cnt[NODES];
  bit [11:0]      fanin_src[NODES*FANIN];
  bit             fanin_written[NODES*FANIN];
  bit [12:0]      key_hook[32];
  bit [12:0]      addr_hook[16];
  bit [12:0]      din_hook[8];
  bit [12:0]      dout_hook[8];
  bit [12:0]      we_hook;
  bit [7:0]       ram_bytes[65536];
  int unsigned    nodes_in_use;
  engine_result_t expected_results[$];
  int             mismatches;
  int             results_checked;

  // Number of fan-in slots of a node written without a hole from slot 0.
  function int leading_written(int n);
    int k;
    k = 0;
    while (k < FANIN && fanin_written[n*FANIN+k]) k++;
    return k;
  endfunction

  function void run_tick(logic [31:0] keys);
    bit          nxt[NODES];
    int          use_n;
    bit          all_high;
    bit          any_addr;
    logic [15:0] ad;
    logic [7:0]  d;
    logic [7:0]  q;
    use_n = (nodes_in_use > NODES) ? NODES : nodes_in_use;
    for (int i = 0; i < NODES; i++) begin
      if (i < use_n) begin
        all_high = 1'b1;
        for (int j = 0; j < fanin_cnt[i]; j++)
          all_high &= node_val[fanin_src[i*FANIN+j]];
        nxt[i] = (fanin_cnt[i] == 0) ? 1'b0 : !all_high;
      end else begin
        nxt[i] = node_val[i];
      end
    end
    for (int s = 0; s < 32; s++)
      if (key_hook[s][12]) nxt[key_hook[s][11:0]] = keys[s];
    // The RAM sees the values from before the tick.
    any_addr = 1'b0;
    ad = '0;
    for (int b = 0; b < 16; b++)
      if (addr_hook[b][12]) begin
        any_addr = 1'b1;
        ad[b] = node_val[addr_hook[b][11:0]];
      end
    if (any_addr) begin
      if (we_hook[12] && node_val[we_hook[11:0]]) begin
        d = '0;
        for (int b = 0; b < 8; b++)
          if (din_hook[b][12]) d[b] = node_val[din_hook[b][11:0]];
        ram_bytes[ad] = d;
      end
      q = ram_bytes[ad];
      for (int b = 0; b < 8; b++)
        if (dout_hook[b][12]) nxt[dout_hook[b][11:0]] = q[b];
    end
    node_val = nxt;
  endfunction

  function bit bind_hook(engine_cmd_t c);
    bit [12:0] v;
    v = c.hook_valid ? {1'b1, c.node} : 13'd0;
    case (c.hook_kind)
      nnte_pkg::HOOK_KEY:  key_hook[c.slot] = v;
      nnte_pkg::HOOK_ADDR: if (c.slot < 16) addr_hook[c.slot[3:0]] = v; else return 1'b1;
      nnte_pkg::HOOK_DIN:  if (c.slot < 8) din_hook[c.slot[2:0]] = v; else return 1'b1;
      nnte_pkg::HOOK_DOUT: if (c.slot < 8) dout_hook[c.slot[2:0]] = v; else return 1'b1;
      nnte_pkg::HOOK_WE:   we_hook = v;
      default: return 1'b1;
    endcase
    return 1'b0;
  endfunction

  function void note_command(engine_cmd_t c);
    engine_result_t r;
    r = '{1'b0, 8'd0, 1'b0};
    case (c.command)
      nnte_pkg::CMD_SET_SRC:
        if (c.slot >= FANIN) r.status = 1'b1;
        else begin
          fanin_src[c.node*FANIN+c.slot] = c.source_node;
          fanin_written[c.node*FANIN+c.slot] = 1'b1;
        end
      nnte_pkg::CMD_SET_CNT:
        if (c.fanin_total > FANIN) r.status = 1'b1;
        else fanin_cnt[c.node] = c.fanin_total;
      nnte_pkg::CMD_POKE:    node_val[c.node] = c.poke_value;
      nnte_pkg::CMD_BIND:    r.status = bind_hook(c);
      nnte_pkg::CMD_TICK:    run_tick(c.key_values);
      nnte_pkg::CMD_RD_NODE: r.node_value = node_val[c.node];
      nnte_pkg::CMD_RD_RAM:  r.mem_byte = ram_bytes[c.mem_address];
      default:               r.status = 1'b1;
    endcase
    expected_results.push_back(r);
  endfunction

  function void check_result(engine_result_t act);
    engine_result_t exp_r;
    results_checked++;
    if (expected_results.size() == 0) begin
      $display("%0t: result with none expected: node_value %0d mem_byte %0d status %0d",
               $time, act.node_value, act.mem_byte, act.status);
      mismatches++;
      return;
    end
    exp_r = expected_results.pop_front();
    if (exp_r.node_value !== act.node_value) begin
      $display("%0t: node_value expected %0d actual %0d",
               $time, exp_r.node_value, act.node_value);
      mismatches++;
    end
    if (exp_r.mem_byte !== act.mem_byte) begin
      $display("%0t: mem_byte expected %0d actual %0d", $time, exp_r.mem_byte, act.mem_byte);
      mismatches++;
    end
    if (exp_r.status !== act.status) begin
      $display("%0t: status expected %0d actual %0d", $time, exp_r.status, act.status);
      mismatches++;
    end
  endfunction
endclass

module tb_nand_netlist_tick_engine_core;
  import nnte_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // The longest quiet stretch is a tick with every node busy on a full
  // fan-in or the clearing pass after reset.
  localparam int QUIET_LIMIT = 400000;
  localparam int ITEM_GOAL   = 140;
  // Commands sent by the directed part before the random phases.
  localparam int DIRECTED_ITEMS = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_command = '0;
  logic [11:0] in_node = '0;
  logic [4:0]  in_slot = '0;
  logic [11:0] in_source_node = '0;
  logic [4:0]  in_fanin_total = '0;
  logic        in_poke_value = 1'b0;
  logic [2:0]  in_hook_kind = '0;
  logic        in_hook_valid = 1'b0;
  logic [31:0] in_key_values = '0;
  logic [15:0] in_mem_address = '0;
  logic        out_valid;
  logic        out_node_value;
  logic [7:0]  out_mem_byte;
  logic        out_status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [12:0] cfg_nodes_in_use = '0;

  tick_engine_scoreboard sb = new();

  int items_sent;
  int ticks_sent;
  int idle_pct;
  int quiet_cycles;

  always #2 clk = ~clk;

  nand_netlist_tick_engine_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_node(in_node), .in_slot(in_slot),
    .in_source_node(in_source_node), .in_fanin_total(in_fanin_total),
    .in_poke_value(in_poke_value), .in_hook_kind(in_hook_kind),
    .in_hook_valid(in_hook_valid), .in_key_values(in_key_values),
    .in_mem_address(in_mem_address),
    .out_valid(out_valid), .out_node_value(out_node_value),
    .out_mem_byte(out_mem_byte), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_nodes_in_use(cfg_nodes_in_use)
  );

  // Result beats are strobed for one cycle and taken at the edge ending it.
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result('{out_node_value, out_mem_byte, out_status});
  end

  // Watchdog: any command, result or register beat counts as progress.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_nand_netlist_tick_engine_core failed");
        $finish;
      end
    end
  end

  // A command of the given kind and node, every other field random; callers then set the ones that matter.
  function automatic engine_cmd_t rand_cmd(cmd_t c, int n);
    engine_cmd_t b;
    b.command     = c;
    b.node        = n[11:0];
    b.slot        = 5'($urandom_range(31));
    b.source_node = 12'($urandom_range(4095));
    b.fanin_total = 5'($urandom_range(31));
    b.poke_value  = 1'($urandom_range(1));
    b.hook_kind   = 3'($urandom_range(7));
    b.hook_valid  = 1'($urandom_range(1));
    b.key_values  = $urandom();
    b.mem_address = 16'($urandom_range(65535));
    return b;
  endfunction

  // Drive one command beat and hold it until the engine takes it. The
  // beat is taken at the edge where start is high and busy is low. The
  // sender then may drop start and go quiet, with a chance of idle_pct percent.
  task automatic issue(engine_cmd_t b);
    start          <= 1'b1;
    in_command     <= b.command;
    in_node        <= b.node;
    in_slot        <= b.slot;
    in_source_node <= b.source_node;
    in_fanin_total <= b.fanin_total;
    in_poke_value  <= b.poke_value;
    in_hook_kind   <= b.hook_kind;
    in_hook_valid  <= b.hook_valid;
    in_key_values  <= b.key_values;
    in_mem_address <= b.mem_address;
    do @(posedge clk); while (busy);
    sb.note_command(b);
    items_sent++;
    if (b.command == CMD_TICK) ticks_sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic drain();
    start <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // The node count register is only written while the engine is idle.
  task automatic write_nodes_in_use(logic [12:0] v);
    drain();
    cfg_valid        <= 1'b1;
    cfg_nodes_in_use <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.nodes_in_use = v;
  endtask

  // Well-formed gate: write k sources from the small working set, then the count.
  task automatic build_gate(int n, int k);
    engine_cmd_t b;
    for (int j = 0; j < k; j++) begin
      b = rand_cmd(CMD_SET_SRC, n);
      b.slot = 5'(j);
      b.source_node = 12'($urandom_range(31));
      issue(b);
    end
    b = rand_cmd(CMD_SET_CNT, n);
    b.fanin_total = 5'(k);
    issue(b);
  endtask

  task automatic random_item();
    engine_cmd_t b;
    int          pick;
    int          n;
    pick = $urandom_range(99);
    n = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(31);
    if (pick < 20) begin
      build_gate($urandom_range(31), ($urandom_range(15) == 0) ? 16 : $urandom_range(1, 4));
    end else if (pick < 28) begin
      // A lone count never reaches past the slots already written.
      b = rand_cmd(CMD_SET_CNT, n);
      b.fanin_total = 5'($urandom_range(sb.leading_written(n)));
      issue(b);
    end else if (pick < 38) begin
      issue(rand_cmd(CMD_POKE, n));
    end else if (pick < 55) begin
      b = rand_cmd(CMD_BIND, $urandom_range(31));
      if ($urandom_range(7) != 0) begin
        b.hook_kind = 3'($urandom_range(4));
        b.slot = 5'($urandom_range(7));
      end
      issue(b);
    end else if (pick < 72) begin
      issue(rand_cmd(CMD_TICK, n));
    end else if (pick < 85) begin
      issue(rand_cmd(CMD_RD_NODE, n));
    end else if (pick < 94) begin
      b = rand_cmd(CMD_RD_RAM, n);
      if ($urandom_range(1)) b.mem_address = 16'($urandom_range(15));
      issue(b);
    end else begin
      // Noise: unknown command, fan-in slot or count out of range.
      b = rand_cmd(CMD_SET_SRC, n);
      case ($urandom_range(2))
        0: b.command = 3'd7;
        1: b.slot = 5'($urandom_range(16, 31));
        default: begin
          b.command = CMD_SET_CNT;
          b.fanin_total = 5'($urandom_range(17, 31));
        end
      endcase
      issue(b);
    end
  endtask

  initial begin
    engine_cmd_t b;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    idle_pct = 0;

    write_nodes_in_use(13'd16);

    // Directed part: reset contents, field extremes and rejected indexes.
    issue(rand_cmd(CMD_RD_NODE, 0));
    b = rand_cmd(CMD_RD_RAM, 0);    b.mem_address = 16'd0;      issue(b);
    b = rand_cmd(CMD_RD_RAM, 0);    b.mem_address = 16'hFFFF;   issue(b);
    b = rand_cmd(CMD_SET_SRC, 4095); b.slot = 5'd15; b.source_node = 12'd4095; issue(b);
    b = rand_cmd(CMD_SET_SRC, 4095); b.slot = 5'd16; issue(b);
    b = rand_cmd(CMD_SET_SRC, 3);    b.slot = 5'd31; issue(b);
    b = rand_cmd(CMD_SET_CNT, 4095); b.fanin_total = 5'd17; issue(b);
    b = rand_cmd(CMD_SET_CNT, 3);    b.fanin_total = 5'd31; issue(b);
    b = rand_cmd(CMD_SET_CNT, 3);    b.fanin_total = 5'd0;  issue(b);
    b = rand_cmd(CMD_POKE, 4095);    b.poke_value = 1'b1;   issue(b);
    b = rand_cmd(CMD_POKE, 2);       b.poke_value = 1'b1;   issue(b);
    b = rand_cmd(CMD_BIND, 7);  b.hook_kind = HOOK_KEY;  b.slot = 5'd31; b.hook_valid = 1'b1;
    issue(b);
    b = rand_cmd(CMD_BIND, 7);  b.hook_kind = HOOK_ADDR; b.slot = 5'd16; issue(b);
    b = rand_cmd(CMD_BIND, 7);  b.hook_kind = HOOK_DIN;  b.slot = 5'd8;  issue(b);
    b = rand_cmd(CMD_BIND, 7);  b.hook_kind = HOOK_DOUT; b.slot = 5'd31; issue(b);
    b = rand_cmd(CMD_BIND, 7);  b.hook_kind = 3'd5; issue(b);
    b = rand_cmd(CMD_BIND, 7);  b.hook_kind = 3'd7; issue(b);
    // Write enable ignores the slot; no address bit is bound yet, so no RAM access.
    b = rand_cmd(CMD_BIND, 2);  b.hook_kind = HOOK_WE; b.slot = 5'd31; b.hook_valid = 1'b1;
    issue(b);
    b = rand_cmd(CMD_TICK, 0);  b.key_values = 32'hFFFF_FFFF; issue(b);
    b = rand_cmd(CMD_TICK, 0);  b.key_values = 32'h0;         issue(b);
    b = rand_cmd(CMD_POKE, 0);  b.command = 3'd7; issue(b);
    issue(rand_cmd(CMD_RD_NODE, 7));
    issue(rand_cmd(CMD_RD_NODE, 4095));
    // A node with the full sixteen sources.
    build_gate(1, 16);

    // Random part in phases, with the node count changed between them.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_nodes_in_use(13'd40);
        1: write_nodes_in_use(13'd4096);
        2: write_nodes_in_use(13'd0);
        3: write_nodes_in_use(13'h1FFF);
        default: write_nodes_in_use(13'd32);
      endcase
      case (phase)
        1, 4: idle_pct = 70;
        2: idle_pct = 23;
        default: idle_pct = 0;
      endcase
      while (items_sent < DIRECTED_ITEMS + (phase + 1) * (ITEM_GOAL - DIRECTED_ITEMS) / 5)
      begin
        random_item();
        if ($urandom_range(39) == 0) drain();
      end
    end

    drain();
    repeat (50) @(posedge clk);
    $display("Sent %0d commands including %0d ticks; %0d result beats checked.",
             items_sent, ticks_sent, sb.results_checked);
    $display("Covered node counts 0, 16, 32, 40, 4096 and 8191 with idle sender phases.");
    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("tb_nand_netlist_tick_engine_core passed");
    end else begin
      $display("tb_nand_netlist_tick_engine_core failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
